/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the keypad RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define KPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/kpd_pkg.sv */
// ---------------------------------------------------------------------------
// kpd_pkg
// Types, constants and the keymap for the keypad scanner with debounce.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpd_pkg;

  localparam int ROWS     = 4;
  localparam int COLUMNS  = 3;
  localparam int PAT_BITS = ROWS * COLUMNS;
  localparam int SLOT_W   = $clog2(COLUMNS);
  localparam int IDX_W    = 4;
  localparam int CHAR_W   = 7;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_RELEASE  = 2'd1,
    CFG_REPEAT   = 2'd2
  } kpd_cfg_idx_t;

  // Item kinds
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd10;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 8'd10;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 8'd20;

  // One result item
  typedef struct packed {
    logic [2:0]          column_select;
    logic                key_valid;
    logic [PAT_BITS-1:0] key_bits;
    logic [IDX_W-1:0]    key_index;
    logic [CHAR_W-1:0]   key_char;
  } kpd_out_t;

  // Key character for a pattern bit position, 0 for positions without a key
  function automatic logic [CHAR_W-1:0] keymap(input logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = 7'h31;  // '1'
      4'd1:    c = 7'h34;  // '4'
      4'd2:    c = 7'h37;  // '7'
      4'd3:    c = 7'h3C;  // '<'
      4'd4:    c = 7'h32;  // '2'
      4'd5:    c = 7'h35;  // '5'
      4'd6:    c = 7'h38;  // '8'
      4'd7:    c = 7'h30;  // '0'
      4'd8:    c = 7'h33;  // '3'
      4'd9:    c = 7'h36;  // '6'
      4'd10:   c = 7'h39;  // '9'
      4'd11:   c = 7'h23;  // '#'
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/kpd_in_if.sv */
// ---------------------------------------------------------------------------
// kpd_in_if
// Valid/ready channel carrying one keypad input item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kpd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] row_pins;

  modport source (output valid, kind, row_pins, input ready);
  modport sink   (input valid, kind, row_pins, output ready);
endinterface

/* hw/rtl/kpd_out_if.sv */
// ---------------------------------------------------------------------------
// kpd_out_if
// Valid/ready channel carrying one keypad result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  column_select;
  logic        key_valid;
  logic [11:0] key_bits;
  logic [3:0]  key_index;
  logic [6:0]  key_char;

  modport source (output valid, column_select, key_valid, key_bits, key_index,
                  key_char, input ready);
  modport sink   (input valid, column_select, key_valid, key_bits, key_index,
                  key_char, output ready);
endinterface

/* hw/rtl/kpd_core.sv */
// ---------------------------------------------------------------------------
// kpd_core
// Scan shift register, column stepping, debounce counters and key latch.
// Updates state on each accepted item and presents its result combinationally.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kpd_core
  import kpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_acc,
  input  logic                 item_kind,
  input  logic [ROWS-1:0]      item_rows,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output kpd_out_t             result
);

  logic [CFG_W-1:0]    debounce_r, release_r, repeat_r;
  logic [PAT_BITS-1:0] row_shift_r, row_shift_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CFG_W-1:0]    press_r, press_nxt;
  logic [CFG_W-1:0]    hold_r, hold_nxt;
  logic [PAT_BITS-1:0] cand_r, cand_nxt;
  logic [PAT_BITS-1:0] latch_r, latch_nxt;

  logic [PAT_BITS-1:0] pat;
  logic [CFG_W-1:0]    press_dec;
  logic [IDX_W-1:0]    low_idx;
  logic [2:0]          col_onehot;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      release_r  <= RELEASE_RST;
      repeat_r   <= REPEAT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_RELEASE:  release_r  <= cfg_wdata;
        CFG_REPEAT:   repeat_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state for scan ticks and reads
  always_comb begin
    row_shift_nxt = row_shift_r;
    slot_nxt      = slot_r;
    press_nxt     = press_r;
    hold_nxt      = hold_r;
    cand_nxt      = cand_r;
    latch_nxt     = latch_r;
    pat           = {row_shift_r[PAT_BITS-ROWS-1:0], ~item_rows};
    press_dec     = press_r - 8'd1;

    if (item_kind == KIND_SCAN) begin
      if (slot_r == SLOT_W'(COLUMNS - 1)) begin
        // full pattern collected: run the debounce step
        slot_nxt      = '0;
        row_shift_nxt = '0;
        if (pat == '0) begin
          press_nxt = debounce_r;
          hold_nxt  = release_r;
        end else if (hold_r != '0) begin
          hold_nxt = hold_r - 8'd1;
        end else begin
          press_nxt = press_dec;
          if (press_dec == debounce_r - 8'd1) begin
            cand_nxt = pat;
          end else if (pat != cand_r) begin
            press_nxt = debounce_r;
            hold_nxt  = release_r;
          end else if (press_dec == '0) begin
            latch_nxt = pat;
            hold_nxt  = repeat_r;
          end
        end
      end else begin
        slot_nxt      = slot_r + SLOT_W'(1);
        row_shift_nxt = pat;
      end
    end else begin
      latch_nxt = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_shift_r <= '0;
      slot_r      <= '0;
      press_r     <= DEBOUNCE_RST;
      hold_r      <= '0;
      cand_r      <= '0;
      latch_r     <= '0;
    end else if (item_acc) begin
      row_shift_r <= row_shift_nxt;
      slot_r      <= slot_nxt;
      press_r     <= press_nxt;
      hold_r      <= hold_nxt;
      cand_r      <= cand_nxt;
      latch_r     <= latch_nxt;
    end
  end

  // Lowest set bit of the latched pattern
  always_comb begin
    low_idx = '0;
    for (int i = PAT_BITS - 1; i >= 0; i--) begin
      if (latch_r[i]) low_idx = IDX_W'(i);
    end
  end

  // Column driven after this item; first column is the top bit
  always_comb begin
    case (slot_nxt)
      2'd0:    col_onehot = 3'b100;
      2'd1:    col_onehot = 3'b010;
      2'd2:    col_onehot = 3'b001;
      default: col_onehot = 3'b000;
    endcase
  end

  // Result of the current item
  always_comb begin
    result               = '0;
    result.column_select = col_onehot;
    if (item_kind == KIND_READ && latch_r != '0) begin
      result.key_valid = 1'b1;
      result.key_bits  = latch_r;
      result.key_index = low_idx;
      result.key_char  = keymap(low_idx);
    end
  end

  `KPD_ASSERT_NOW(a_slot_range, 1'b1, slot_r != 2'd3, "column slot out of range")
  `KPD_ASSERT_NEXT(a_read_clears, item_acc && item_kind == KIND_READ, latch_r == '0,
                   "latch not cleared by read")
  `KPD_ASSERT_NEXT(a_idle_holds, !item_acc && !cfg_we, $stable(latch_r) && $stable(press_r),
                   "state moved without an item")

endmodule

/* hw/rtl/matrix_keypad_scan_debounce_top.sv */
// ---------------------------------------------------------------------------
// matrix_keypad_scan_debounce_top
// 4x3 keypad scanner with debounce, valid/ready item channels.
// ---------------------------------------------------------------------------
// Result: registered; valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the single result register is refilled
//   in the cycle it is taken, so input ready follows !out_valid || out_ready.
// Reset: synchronous, active low; clears the scan, hold counter and latch,
//   reloads press counter and register defaults. No clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_keypad_scan_debounce_top
  import kpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  kpd_in_if.sink               in_ch,
  kpd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic     out_valid_r;
  kpd_out_t res_r;
  kpd_out_t res_nxt;
  logic     in_fire;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  kpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_acc  (in_fire),
    .item_kind (in_ch.kind),
    .item_rows (in_ch.row_pins),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .result    (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.column_select = res_r.column_select;
  assign out_ch.key_valid     = res_r.key_valid;
  assign out_ch.key_bits      = res_r.key_bits;
  assign out_ch.key_index     = res_r.key_index;
  assign out_ch.key_char      = res_r.key_char;

  `KPD_ASSERT_NEXT(a_scan_no_key, in_fire && in_ch.kind == KIND_SCAN,
                   out_valid_r && !res_r.key_valid && res_r.key_bits == '0,
                   "scan item returned key data")
  `KPD_ASSERT_NOW(a_col_onehot, out_valid_r, $onehot(res_r.column_select),
                  "column select not one-hot")
  `KPD_ASSERT_NOW(a_valid_bits, out_valid_r && res_r.key_valid, res_r.key_bits != '0,
                  "key valid with empty pattern")

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x3 keypad scanner with debounce.
// A short table of directed items opens the run: a read after reset, extreme
// row pin levels, and two keys debounced down to a latch and read back.
// Random phases follow under several register settings. Most of their items
// hold a key pattern across full scans, with bounce and reads mixed in; the
// rest are noise. Every result is checked against a local prediction of the
// scan, debounce and latch logic. Both channels idle at random, and once the
// result side holds off long enough to back the block up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kpd_pkg::*;

  localparam int ITEMS_PER_PHASE = 110;
  localparam int RANDOM_PHASES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int END_SETTLE      = 20;
  localparam int PRINT_CAP       = 50;

  // Key legend by pattern bit position
  localparam logic [6:0] KEY_LEGEND [12] = '{
    7'h31, 7'h34, 7'h37, 7'h3C,   // 1 4 7 <
    7'h32, 7'h35, 7'h38, 7'h30,   // 2 5 8 0
    7'h33, 7'h36, 7'h39, 7'h23    // 3 6 9 #
  };

  typedef struct packed {
    logic     typed;
    kpd_out_t want;
  } item_note_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] pins;
    logic       typed;
    kpd_out_t   want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  kpd_in_if  in_ch();
  kpd_out_if out_ch();

  matrix_keypad_scan_debounce_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state and register copies
  logic [7:0]  deb_reload, settle_reload, repeat_reload;
  logic [11:0] row_shift, cand_key, latched_key;
  logic [1:0]  col_slot;
  logic [7:0]  press_cnt, hold_cnt;

  item_note_t item_notes[$];
  kpd_out_t   pending_reports[$];
  dir_row_t   dir_tab[$];

  int  mismatches = 0;
  int  scan_items = 0;
  int  read_items = 0;
  int  key_hits = 0;
  int  settings_used = 0;
  int  gen_slot = 0;
  int  quiet_cycles = 0;
  logic [11:0] keys_seen = '0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  hold_off_req = 1'b0;

  // Next result of the keypad for one accepted item; advances the state
  function automatic kpd_out_t predict_report(input logic kind, input logic [3:0] pins);
    kpd_out_t    r;
    logic [11:0] pat;
    logic [11:0] key;
    r = '0;
    if (kind == KIND_SCAN) begin
      row_shift = {row_shift[7:0], ~pins};
      if (col_slot == 2'd2) begin
        col_slot = 2'd0;
        pat = row_shift;
        row_shift = '0;
        if (pat == '0) begin
          // released: restart debouncing
          press_cnt = deb_reload;
          hold_cnt = settle_reload;
        end else if (hold_cnt != 8'd0) begin
          hold_cnt = hold_cnt - 8'd1;
        end else begin
          press_cnt = press_cnt - 8'd1;
          if (press_cnt == deb_reload - 8'd1) begin
            cand_key = pat;
          end else if (pat != cand_key) begin
            press_cnt = deb_reload;
            hold_cnt = settle_reload;
          end else if (press_cnt == 8'd0) begin
            latched_key = pat;
            hold_cnt = repeat_reload;
          end
        end
      end else begin
        col_slot = col_slot + 2'd1;
      end
    end else begin
      // read and clear the latch; lowest set bit picks the key
      key = latched_key;
      latched_key = '0;
      if (key != '0) begin
        r.key_valid = 1'b1;
        r.key_bits = key;
        for (int i = 11; i >= 0; i--) begin
          if (key[i]) r.key_index = i[3:0];
        end
        r.key_char = KEY_LEGEND[r.key_index];
      end
    end
    r.column_select = 3'b100 >> col_slot;
    return r;
  endfunction

  function automatic dir_row_t drow(input logic kind, input logic [3:0] pins,
                                    input logic typed, input logic [2:0] cs,
                                    input logic kv, input logic [11:0] bits,
                                    input logic [3:0] idx, input logic [6:0] ch);
    dir_row_t d;
    d.kind = kind;
    d.pins = pins;
    d.typed = typed;
    d.want.column_select = cs;
    d.want.key_valid = kv;
    d.want.key_bits = bits;
    d.want.key_index = idx;
    d.want.key_char = ch;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one item after a random gap (none in a burst); returns at the edge it is taken
  task automatic send_item(input logic kind, input logic [3:0] pins,
                           input logic typed, input kpd_out_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_notes.push_back({typed, want});
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.row_pins <= pins;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == KIND_SCAN) gen_slot = (gen_slot == 2) ? 0 : gen_slot + 1;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (item_notes.size() != 0 || pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic set_config(input logic [7:0] deb, input logic [7:0] rel,
                            input logic [7:0] rep);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_RELEASE;
    cfg_wdata <= rel;
    @(posedge clk);
    cfg_index <= CFG_REPEAT;
    cfg_wdata <= rep;
    @(posedge clk);
    cfg_we <= 1'b0;
    deb_reload = deb;
    settle_reload = rel;
    repeat_reload = rep;
    settings_used++;
  endtask

  // Accepted input items: predict and queue the result
  always @(posedge clk) begin : accept_side
    item_note_t note;
    kpd_out_t   pred;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      note = item_notes.pop_front();
      pred = predict_report(in_ch.kind, in_ch.row_pins);
      pending_reports.push_back(note.typed ? note.want : pred);
      if (in_ch.kind == KIND_SCAN) scan_items++;
      else read_items++;
    end
  end

  // Accepted results: compare with the oldest expectation
  always @(posedge clk) begin : result_check
    kpd_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing waiting, column_select",
                        out_ch.column_select, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.column_select !== want.column_select)
          report_mismatch("column_select", out_ch.column_select, want.column_select);
        if (out_ch.key_valid !== want.key_valid)
          report_mismatch("key_valid", out_ch.key_valid, want.key_valid);
        if (out_ch.key_bits !== want.key_bits)
          report_mismatch("key_bits", out_ch.key_bits, want.key_bits);
        if (out_ch.key_index !== want.key_index)
          report_mismatch("key_index", out_ch.key_index, want.key_index);
        if (out_ch.key_char !== want.key_char)
          report_mismatch("key_char", out_ch.key_char, want.key_char);
        if (want.key_valid) begin
          key_hits++;
          keys_seen[want.key_index] = 1'b1;
        end
      end
    end
  end

  // Result side: random stalls, bursts, and one long hold-off on request
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if (hold_off_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Watchdog: no item moving on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int          in_phase;
    int          scans;
    logic [11:0] pat;
    logic [11:0] nib;
    logic [3:0]  pins;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_SCAN;
    in_ch.row_pins <= 4'h0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= '0;

    // state right after reset
    deb_reload = DEBOUNCE_RST;
    settle_reload = RELEASE_RST;
    repeat_reload = REPEAT_RST;
    row_shift = '0;
    col_slot = 2'd0;
    press_cnt = 8'd10;
    hold_cnt = 8'd0;
    cand_key = '0;
    latched_key = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: fastest debounce so keys latch within a few scans
    set_config(8'd2, 8'd0, 8'd0);
    // read after reset, then a scan with all four rows low in the last column
    dir_tab.push_back(drow(KIND_READ, 4'hF, 1, 3'b100, 0, 12'h000, 0, 7'h00));
    dir_tab.push_back(drow(KIND_SCAN, 4'hF, 1, 3'b010, 0, 12'h000, 0, 7'h00));
    dir_tab.push_back(drow(KIND_SCAN, 4'hF, 1, 3'b001, 0, 12'h000, 0, 7'h00));
    dir_tab.push_back(drow(KIND_SCAN, 4'h0, 1, 3'b100, 0, 12'h000, 0, 7'h00));
    // same pattern twice more: capture, then latch
    repeat (2) begin
      dir_tab.push_back(drow(KIND_SCAN, 4'hF, 0, 3'b000, 0, 12'h000, 0, 7'h00));
      dir_tab.push_back(drow(KIND_SCAN, 4'hF, 0, 3'b000, 0, 12'h000, 0, 7'h00));
      dir_tab.push_back(drow(KIND_SCAN, 4'h0, 0, 3'b000, 0, 12'h000, 0, 7'h00));
    end
    // lowest of the four pressed bits wins; second read finds the latch clear
    dir_tab.push_back(drow(KIND_READ, 4'h0, 1, 3'b100, 1, 12'h00F, 0, 7'h31));
    dir_tab.push_back(drow(KIND_READ, 4'h5, 1, 3'b100, 0, 12'h000, 0, 7'h00));
    // top bit key: bottom row of the first column, press counter wraps
    repeat (3) begin
      dir_tab.push_back(drow(KIND_SCAN, 4'h7, 0, 3'b000, 0, 12'h000, 0, 7'h00));
      dir_tab.push_back(drow(KIND_SCAN, 4'hF, 0, 3'b000, 0, 12'h000, 0, 7'h00));
      dir_tab.push_back(drow(KIND_SCAN, 4'hF, 0, 3'b000, 0, 12'h000, 0, 7'h00));
    end
    dir_tab.push_back(drow(KIND_READ, 4'hA, 1, 3'b100, 1, 12'h800, 11, 7'h23));
    // read in mid scan repeats the driven column, then a release
    dir_tab.push_back(drow(KIND_SCAN, 4'hF, 1, 3'b010, 0, 12'h000, 0, 7'h00));
    dir_tab.push_back(drow(KIND_READ, 4'h0, 1, 3'b010, 0, 12'h000, 0, 7'h00));
    dir_tab.push_back(drow(KIND_SCAN, 4'hF, 0, 3'b000, 0, 12'h000, 0, 7'h00));
    dir_tab.push_back(drow(KIND_SCAN, 4'hF, 0, 3'b000, 0, 12'h000, 0, 7'h00));
    foreach (dir_tab[i]) begin
      tx_burst = (i < 12);
      send_item(dir_tab[i].kind, dir_tab[i].pins, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: set_config(DEBOUNCE_RST, RELEASE_RST, REPEAT_RST);
        1: set_config(8'd2, 8'd0, 8'd0);
        2: set_config(8'd255, 8'd255, 8'd255);
        3: set_config(8'd3, 8'd1, 8'd0);
        4: set_config(8'd2, 8'd0, 8'd255);
        5: set_config(8'd255, 8'd0, 8'd0);
        6: set_config(8'($urandom_range(2, 8)), 8'($urandom_range(0, 6)),
                      8'($urandom_range(0, 10)));
        default: set_config(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
      endcase
      // back the block up with a long result-side hold-off
      if (ph == 3) hold_off_req = 1'b1;
      in_phase = 0;
      while (in_phase < ITEMS_PER_PHASE) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0) begin
          // a key pattern held over full scans, with bounce and reads mixed in
          case ($urandom_range(0, 9))
            0:       pat = '0;
            1, 2:    pat = 12'($urandom_range(1, 4095));
            default: pat = 12'h1 << $urandom_range(0, 11);
          endcase
          scans = $urandom_range(1, 40);
          for (int t = 0; t < scans * 3; t++) begin
            if ($urandom_range(0, 7) == 0) begin
              send_item(KIND_READ, 4'($urandom), 1'b0, '0);
              in_phase++;
            end
            nib = pat >> (4 * (2 - gen_slot));
            pins = ($urandom_range(0, 39) == 0) ? 4'($urandom) : ~nib[3:0];
            send_item(KIND_SCAN, pins, 1'b0, '0);
            in_phase++;
          end
          if ($urandom_range(0, 1) == 1) begin
            send_item(KIND_READ, 4'($urandom), 1'b0, '0);
            in_phase++;
          end
        end else begin
          // noise: random pins and stray reads
          repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 3) == 0)
              send_item(KIND_READ, 4'($urandom), 1'b0, '0);
            else
              send_item(KIND_SCAN, 4'($urandom), 1'b0, '0);
            in_phase++;
          end
        end
      end
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    $display("Run covered %0d items (%0d scan ticks, %0d reads) under %0d register settings",
             scan_items + read_items, scan_items, read_items, settings_used);
    $display("Reads returned a debounced key %0d times, %0d of 12 key positions seen",
             key_hits, $countones(keys_seen));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/kpd_pkg.sv
hw/rtl/kpd_in_if.sv
hw/rtl/kpd_out_if.sv
hw/rtl/kpd_core.sv
hw/rtl/matrix_keypad_scan_debounce_top.sv
tb/tb_top.sv
